>>> rtl/core/fresnel_pkg.sv
`default_nettype none
package fresnel_pkg;
    localparam int COS_FRAC_BITS_DEF = 16;
    localparam int INDEX_FRAC_BITS_DEF = 13;
    localparam int IDX_W = 16;
    localparam logic [IDX_W-1:0] N1_RESET = 16'd8192;
    localparam logic [IDX_W-1:0] N2_RESET = 16'd12288;
    localparam logic REG_N1 = 1'b0;
    localparam logic REG_N2 = 1'b1;
endpackage
`default_nettype wire

>>> rtl/core/fresnel_sqrt_stage.sv
`default_nettype none
module fresnel_sqrt_stage
    import fresnel_pkg::*;
#(
    parameter int CW = 17,
    parameter int PW = 120,
    parameter int BIT = 0
)
(
    input  wire logic          hold,
    input  wire logic [CW-1:0] c_in,
    input  wire logic [PW-1:0] p_in,
    input  wire logic [PW-1:0] q_in,
    input  wire logic [PW-1:0] n2sq,
    input  wire logic [PW-1:0] room,
    input  wire logic [CW-1:0] one,
    output      logic [CW-1:0] c_out,
    output      logic [PW-1:0] p_out,
    output      logic [PW-1:0] q_out
);
    // p_in holds c * n2^2 and q_in holds c^2 * n2^2 for the bits decided so far.
    logic [CW-1:0] cand;
    logic [PW-1:0] p_cand;
    logic [PW-1:0] q_cand;
    always_comb
    begin
        cand = c_in | (CW'(1) << BIT);
        p_cand = p_in + (n2sq << BIT);
        q_cand = q_in + (p_in << (BIT + 1)) + (n2sq << (2 * BIT));
        if (!hold && cand <= one && q_cand <= room)
        begin
            c_out = cand;
            p_out = p_cand;
            q_out = q_cand;
        end
        else
        begin
            c_out = c_in;
            p_out = p_in;
            q_out = q_in;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/fresnel_ratio_stage.sv
`default_nettype none
module fresnel_ratio_stage
    import fresnel_pkg::*;
#(
    parameter int W = 34
)
(
    input  wire logic [W:0]   r_in,
    input  wire logic [W-1:0] den,
    output      logic [W:0]   r_out,
    output      logic         q_bit
);
    logic [W+1:0] sh;
    always_comb
    begin
        sh = {r_in, 1'b0};
        if (sh >= (W+2)'(den))
        begin
            r_out = (W+1)'(sh - (W+2)'(den));
            q_bit = 1'b1;
        end
        else
        begin
            r_out = sh[W:0];
            q_bit = 1'b0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/fresnel_dielectric_reflectance.sv
// Unpolarized Fresnel reflectance of a dielectric boundary.
// Config: write enable cfg_we, cfg_index (0 incident, 1 transmitted index)
// and cfg_data; the user writes only while the block is idle, unenforced.
// An item is accepted when start is high and busy is low; busy is always
// low, so one item may enter in every cycle.
// Each item gives one result, shown for one cycle with done high.
// The stages, in order, are an input stage, a bound stage, a square root
// setup stage, one stage per bit of the transmitted cosine, a product stage,
// a divider setup stage that gives the first quotient bit, one stage per
// further quotient bit of the two parallel ratio dividers, a squaring stage
// and the rounding and output stage.
// Throughput is one item per cycle, set by the fully pipelined datapath.
// Reset clears all valid bits and loads the default indices (1.0, 1.5).
// The receiver cannot stall; results are taken as they come.
`default_nettype none
module fresnel_dielectric_reflectance
    import fresnel_pkg::*;
#(
    parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [IDX_W-1:0]         cfg_data,
    input  wire logic                     start,
    output      logic                     busy,
    input  wire logic                     kind,
    input  wire logic [COS_FRAC_BITS:0]   cos_incident,
    input  wire logic [COS_FRAC_BITS:0]   cos_transmit_given,
    output      logic                     done,
    output      logic [COS_FRAC_BITS:0]   reflectance,
    output      logic [COS_FRAC_BITS:0]   cos_transmit,
    output      logic                     total_reflection,
    output      logic                     degenerate
);
    localparam int CW = COS_FRAC_BITS + 1;
    localparam int NW = 2 * IDX_W;
    localparam int PW = 4 * CW + 2 * IDX_W + 4;
    localparam int RB = COS_FRAC_BITS + 4;
    localparam int DW = IDX_W + CW + 1;
    localparam int SH = 2 * RB + 1 - COS_FRAC_BITS;
    localparam int NS = CW;
    localparam int ND = RB;
    localparam logic [CW-1:0] ONE = CW'(1) << COS_FRAC_BITS;

    typedef struct packed {
        logic             kind;
        logic [CW-1:0]    c1;
        logic [CW-1:0]    c2;
        logic [IDX_W-1:0] n1;
        logic [IDX_W-1:0] n2;
        logic [NW-1:0]    n1sq;
        logic [NW-1:0]    n2sq;
        logic [2*CW-1:0]  c1sq;
    } in_t;

    typedef struct packed {
        logic             kind;
        logic [CW-1:0]    c1;
        logic [CW-1:0]    c2;
        logic [IDX_W-1:0] n1;
        logic [IDX_W-1:0] n2;
        logic [NW-1:0]    n2sq;
        logic [PW-1:0]    lhs;
    } bd_t;

    typedef struct packed {
        logic             kind;
        logic             tir;
        logic [CW-1:0]    c1;
        logic [CW-1:0]    c2;
        logic [IDX_W-1:0] n1;
        logic [IDX_W-1:0] n2;
        logic [PW-1:0]    n2sq;
        logic [PW-1:0]    room;
        logic [PW-1:0]    p;
        logic [PW-1:0]    q;
    } sq_t;

    typedef struct packed {
        logic          tir;
        logic [CW-1:0] c2;
        logic [DW-1:0] pa_x;
        logic [DW-1:0] pa_y;
        logic [DW-1:0] pe_x;
        logic [DW-1:0] pe_y;
    } pr_t;

    typedef struct packed {
        logic          tir;
        logic          degen;
        logic [CW-1:0] c2;
        logic [DW-1:0] den_a;
        logic [DW-1:0] den_b;
        logic [DW:0]   r_a;
        logic [DW:0]   r_b;
        logic [RB:0]   q_a;
        logic [RB:0]   q_b;
    } dv_t;

    logic [IDX_W-1:0] n1_reg;
    logic [IDX_W-1:0] n2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_reg <= N1_RESET;
            n2_reg <= N2_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_N1)
            begin
                n1_reg <= cfg_data;
            end
            else
            begin
                n2_reg <= cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    // Valid bits of every stage.
    logic          in_v_reg;
    logic          bd_v_reg;
    logic [NS:0]   rt_v_reg;
    logic          pr_v_reg;
    logic [ND:0]   dv_v_reg;
    logic          sq_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            bd_v_reg <= 1'b0;
            rt_v_reg <= '0;
            pr_v_reg <= 1'b0;
            dv_v_reg <= '0;
            sq_v_reg <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
            bd_v_reg <= in_v_reg;
            rt_v_reg <= {rt_v_reg[NS-1:0], bd_v_reg};
            pr_v_reg <= rt_v_reg[NS];
            dv_v_reg <= {dv_v_reg[ND-1:0], pr_v_reg};
            sq_v_reg <= dv_v_reg[ND];
            done <= sq_v_reg;
        end
    end

    // Input stage: saturate cosines and form the squares.
    in_t in_next;
    in_t in_reg;
    logic [CW-1:0] c1s;
    always_comb
    begin
        c1s = (cos_incident > ONE) ? ONE : cos_incident;
        in_next.kind = kind;
        in_next.c1 = c1s;
        in_next.c2 = (cos_transmit_given > ONE) ? ONE : cos_transmit_given;
        in_next.n1 = n1_reg;
        in_next.n2 = n2_reg;
        in_next.n1sq = NW'(n1_reg) * NW'(n1_reg);
        in_next.n2sq = NW'(n2_reg) * NW'(n2_reg);
        in_next.c1sq = (2*CW)'(c1s) * (2*CW)'(c1s);
    end

    // Bound stage: n1^2 (1 - c1^2).
    bd_t bd_next;
    bd_t bd_reg;
    always_comb
    begin
        bd_next.kind = in_reg.kind;
        bd_next.c1 = in_reg.c1;
        bd_next.c2 = in_reg.c2;
        bd_next.n1 = in_reg.n1;
        bd_next.n2 = in_reg.n2;
        bd_next.n2sq = in_reg.n2sq;
        bd_next.lhs = PW'(in_reg.n1sq)
            * ((PW'(1) << (2 * COS_FRAC_BITS)) - PW'(in_reg.c1sq));
    end

    // Square root setup: total reflection test and remaining room.
    sq_t s0_next;
    sq_t sq_reg [0:NS];
    logic [PW-1:0] rhs;
    always_comb
    begin
        rhs = PW'(bd_reg.n2sq) << (2 * COS_FRAC_BITS);
        s0_next.kind = bd_reg.kind;
        s0_next.tir = !bd_reg.kind && (rhs <= bd_reg.lhs);
        s0_next.c1 = bd_reg.c1;
        s0_next.c2 = bd_reg.kind ? bd_reg.c2 : '0;
        s0_next.n1 = bd_reg.n1;
        s0_next.n2 = bd_reg.n2;
        s0_next.n2sq = PW'(bd_reg.n2sq);
        s0_next.room = rhs - bd_reg.lhs;
        s0_next.p = '0;
        s0_next.q = '0;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        bd_reg <= bd_next;
        sq_reg[0] <= s0_next;
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_sqrt
            logic [CW-1:0] c_nx;
            logic [PW-1:0] p_nx;
            logic [PW-1:0] q_nx;
            fresnel_sqrt_stage #(.CW(CW), .PW(PW), .BIT(NS - 1 - g)) u_sq (
                .hold(sq_reg[g].kind || sq_reg[g].tir), .c_in(sq_reg[g].c2),
                .p_in(sq_reg[g].p), .q_in(sq_reg[g].q), .n2sq(sq_reg[g].n2sq),
                .room(sq_reg[g].room), .one(ONE), .c_out(c_nx), .p_out(p_nx),
                .q_out(q_nx));
            always_ff @(posedge clk)
            begin
                sq_reg[g+1] <= '{kind: sq_reg[g].kind, tir: sq_reg[g].tir,
                    c1: sq_reg[g].c1, c2: c_nx,
                    n1: sq_reg[g].n1, n2: sq_reg[g].n2, n2sq: sq_reg[g].n2sq,
                    room: sq_reg[g].room, p: p_nx, q: q_nx};
            end
        end
    endgenerate

    // Product stage: the four index and cosine products.
    pr_t pr_next;
    pr_t pr_reg;
    always_comb
    begin
        pr_next.tir = sq_reg[NS].tir;
        pr_next.c2 = sq_reg[NS].tir ? '0 : sq_reg[NS].c2;
        pr_next.pa_x = DW'(sq_reg[NS].n2) * DW'(sq_reg[NS].c1);
        pr_next.pa_y = DW'(sq_reg[NS].n1) * DW'(sq_reg[NS].c2);
        pr_next.pe_x = DW'(sq_reg[NS].n1) * DW'(sq_reg[NS].c1);
        pr_next.pe_y = DW'(sq_reg[NS].n2) * DW'(sq_reg[NS].c2);
    end

    // Divider setup: numerators, denominators and the first quotient bit.
    dv_t dv_reg [0:ND];
    dv_t d0_next;
    logic [DW-1:0] na, ne;
    always_comb
    begin
        na = (pr_reg.pa_x > pr_reg.pa_y) ? pr_reg.pa_x - pr_reg.pa_y
                                         : pr_reg.pa_y - pr_reg.pa_x;
        ne = (pr_reg.pe_x > pr_reg.pe_y) ? pr_reg.pe_x - pr_reg.pe_y
                                         : pr_reg.pe_y - pr_reg.pe_x;
        d0_next.tir = pr_reg.tir;
        d0_next.c2 = pr_reg.c2;
        d0_next.den_a = pr_reg.pa_x + pr_reg.pa_y;
        d0_next.den_b = pr_reg.pe_x + pr_reg.pe_y;
        d0_next.degen = (d0_next.den_a == '0) && (d0_next.den_b == '0);
        d0_next.q_a = (na >= d0_next.den_a) ? (RB+1)'(1) : '0;
        d0_next.r_a = (na >= d0_next.den_a) ? (DW+1)'(na - d0_next.den_a) : (DW+1)'(na);
        d0_next.q_b = (ne >= d0_next.den_b) ? (RB+1)'(1) : '0;
        d0_next.r_b = (ne >= d0_next.den_b) ? (DW+1)'(ne - d0_next.den_b) : (DW+1)'(ne);
    end

    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next;
        dv_reg[0] <= d0_next;
    end

    generate
        for (g = 0; g < ND; g++)
        begin : g_div
            logic [DW:0] ra_nx, rb_nx;
            logic qa, qb;
            fresnel_ratio_stage #(.W(DW)) u_a (.r_in(dv_reg[g].r_a),
                .den(dv_reg[g].den_a), .r_out(ra_nx), .q_bit(qa));
            fresnel_ratio_stage #(.W(DW)) u_b (.r_in(dv_reg[g].r_b),
                .den(dv_reg[g].den_b), .r_out(rb_nx), .q_bit(qb));
            always_ff @(posedge clk)
            begin
                dv_reg[g+1] <= '{tir: dv_reg[g].tir,
                    degen: dv_reg[g].degen, c2: dv_reg[g].c2,
                    den_a: dv_reg[g].den_a, den_b: dv_reg[g].den_b,
                    r_a: ra_nx, r_b: rb_nx,
                    q_a: {dv_reg[g].q_a[RB-1:0], qa},
                    q_b: {dv_reg[g].q_b[RB-1:0], qb}};
            end
        end
    endgenerate

    // Squaring stage.
    logic sq_tir_reg, sq_dg_reg;
    logic [CW-1:0] sq_c2_reg;
    logic [2*RB+1:0] pa_reg, pe_reg;
    logic [RB:0] qa_eff, qb_eff;
    assign qa_eff = (dv_reg[ND].den_a == '0) ? (RB+1)'(1) << RB : dv_reg[ND].q_a;
    assign qb_eff = (dv_reg[ND].den_b == '0) ? (RB+1)'(1) << RB : dv_reg[ND].q_b;
    always_ff @(posedge clk)
    begin
        sq_tir_reg <= dv_reg[ND].tir;
        sq_dg_reg <= dv_reg[ND].degen;
        sq_c2_reg <= dv_reg[ND].c2;
        pa_reg <= (2*RB+2)'(qa_eff) * (2*RB+2)'(qa_eff);
        pe_reg <= (2*RB+2)'(qb_eff) * (2*RB+2)'(qb_eff);
    end

    // Rounding and output stage.
    logic [2*RB+2:0] sum;
    logic [2*RB+2:0] rnd;
    logic [CW-1:0] refl;
    always_comb
    begin
        sum = (2*RB+3)'(pa_reg) + (2*RB+3)'(pe_reg);
        rnd = (sum + ((2*RB+3)'(1) << (SH - 1))) >> SH;
        refl = (rnd > (2*RB+3)'(ONE)) ? ONE : rnd[CW-1:0];
        if (sq_tir_reg || sq_dg_reg)
        begin
            refl = ONE;
        end
    end
    always_ff @(posedge clk)
    begin
        reflectance <= refl;
        cos_transmit <= sq_c2_reg;
        total_reflection <= sq_tir_reg;
        degenerate <= sq_dg_reg && !sq_tir_reg;
    end
endmodule
`default_nettype wire

>>> test/fresnel_dielectric_reflectance_tb.sv
module fresnel_dielectric_reflectance_tb;
    import fresnel_pkg::*;

    localparam int CFB = COS_FRAC_BITS_DEF;
    localparam logic [63:0] COS_ONE = 64'd1 << CFB;
    localparam int RATIO_BITS = CFB + 4;
    localparam int ROUND_SH = 2 * RATIO_BITS + 1 - CFB;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [CFB:0] refl;
        logic [CFB:0] cos_t;
        logic         tir;
        logic         degen;
    } fresnel_result_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic           cfg_index;
    logic [IDX_W-1:0] cfg_data;
    logic           start;
    logic           busy;
    logic           kind;
    logic [CFB:0]   cos_incident;
    logic [CFB:0]   cos_transmit_given;
    logic           done;
    logic [CFB:0]   reflectance;
    logic [CFB:0]   cos_transmit;
    logic           total_reflection;
    logic           degenerate;

    logic [IDX_W-1:0] n_inc;
    logic [IDX_W-1:0] n_trn;
    fresnel_result_t  expected_q[$];
    int               mismatches;
    int               idle_pct;

    fresnel_dielectric_reflectance u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .kind(kind),
        .cos_incident(cos_incident), .cos_transmit_given(cos_transmit_given),
        .done(done), .reflectance(reflectance), .cos_transmit(cos_transmit),
        .total_reflection(total_reflection), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] amplitude_ratio(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] num;
        logic [63:0] den;
        num = (x > y) ? x - y : y - x;
        den = x + y;
        if (den == 0)
            return COS_ONE << 4;
        return (num << RATIO_BITS) / den;
    endfunction

    function automatic fresnel_result_t fresnel_reflect(input logic k, input logic [CFB:0] ci,
                                                        input logic [CFB:0] cg);
        fresnel_result_t r;
        logic [63:0]  n1;
        logic [63:0]  n2;
        logic [63:0]  c1;
        logic [63:0]  c2;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [63:0]  cand;
        logic [63:0]  rpa;
        logic [63:0]  rpe;
        logic [63:0]  sum;
        logic [63:0]  refl;
        n1 = 64'(n_inc);
        n2 = 64'(n_trn);
        c1 = (64'(ci) > COS_ONE) ? COS_ONE : 64'(ci);
        if (k == 1'b0)
        begin
            lhs = 128'(n1 * n1) * 128'(COS_ONE * COS_ONE - c1 * c1);
            rhs = 128'(n2 * n2) * 128'(COS_ONE * COS_ONE);
            if (rhs <= lhs)
            begin
                r.refl = COS_ONE[CFB:0];
                r.cos_t = '0;
                r.tir = 1'b1;
                r.degen = 1'b0;
                return r;
            end
            c2 = 0;
            for (int b = CFB; b >= 0; b--)
            begin
                cand = c2 | (64'd1 << b);
                if (cand <= COS_ONE && 128'(cand * cand) * 128'(n2 * n2) + lhs <= rhs)
                    c2 = cand;
            end
        end
        else
        begin
            c2 = (64'(cg) > COS_ONE) ? COS_ONE : 64'(cg);
        end
        r.degen = (n2 * c1 + n1 * c2 == 0) && (n1 * c1 + n2 * c2 == 0);
        if (r.degen)
        begin
            refl = COS_ONE;
        end
        else
        begin
            rpa = amplitude_ratio(n2 * c1, n1 * c2);
            rpe = amplitude_ratio(n1 * c1, n2 * c2);
            sum = rpa * rpa + rpe * rpe;
            refl = (sum + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
            if (refl > COS_ONE)
                refl = COS_ONE;
        end
        r.refl = refl[CFB:0];
        r.cos_t = c2[CFB:0];
        r.tir = 1'b0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        fresnel_result_t got;
        fresnel_result_t exp_r;
        if (rst_n && done)
        begin
            got = '{reflectance, cos_transmit, total_reflection, degenerate};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    task automatic send_item(input logic k, input logic [CFB:0] ci, input logic [CFB:0] cg);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        kind <= k;
        cos_incident <= ci;
        cos_transmit_given <= cg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(fresnel_reflect(k, ci, cg));
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_index(input logic idx, input logic [IDX_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_N1)
            n_inc = value;
        else
            n_trn = value;
        @(negedge clk);
    endtask

    function automatic logic [CFB:0] random_cos;
        case ($urandom_range(9))
            0: return '0;
            1: return COS_ONE[CFB:0];
            2: return (CFB+1)'($urandom_range(32'(2**(CFB+1) - 1), 32'(COS_ONE + 1)));
            3: return (CFB+1)'($urandom_range(255));
            default: return (CFB+1)'($urandom_range(32'(COS_ONE)));
        endcase
    endfunction

    task automatic test_directed;
        idle_pct = 10;
        send_item(1'b0, '0, '0);
        send_item(1'b0, COS_ONE[CFB:0], '1);
        send_item(1'b0, '1, '0);
        send_item(1'b1, COS_ONE[CFB:0], COS_ONE[CFB:0]);
        send_item(1'b1, '1, '1);
        send_item(1'b1, '0, '0);
        send_item(1'b1, 17'd12345, '0);
        send_item(1'b1, '0, 17'd40000);
        drain();
        write_index(REG_N1, 16'd12288);
        write_index(REG_N2, 16'd8192);
        send_item(1'b0, '0, '0);
        send_item(1'b0, 17'd20000, '0);
        send_item(1'b0, 17'd50000, '0);
        send_item(1'b0, COS_ONE[CFB:0], '0);
        drain();
        write_index(REG_N2, 16'd0);
        send_item(1'b0, COS_ONE[CFB:0], '0);
        send_item(1'b1, '0, '0);
        send_item(1'b1, 17'd30000, 17'd30000);
        drain();
        write_index(REG_N1, 16'd0);
        write_index(REG_N2, 16'hFFFF);
        send_item(1'b0, 17'd1, '0);
        send_item(1'b1, '0, '0);
        send_item(1'b1, '0, 17'd100);
        drain();
    endtask

    task automatic test_random(input int count, input int pct,
                               input logic [IDX_W-1:0] n1, input logic [IDX_W-1:0] n2);
        idle_pct = pct;
        write_index(REG_N1, n1);
        write_index(REG_N2, n2);
        for (int i = 0; i < count; i++)
        begin
            send_item(1'($urandom_range(1)), random_cos(), random_cos());
            if (i == count / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_N1;
        cfg_data = '0;
        start = 1'b0;
        kind = 1'b0;
        cos_incident = '0;
        cos_transmit_given = '0;
        n_inc = N1_RESET;
        n_trn = N2_RESET;
        mismatches = 0;
        idle_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(300, 10, N1_RESET, N2_RESET);
        test_random(300, 10, 16'd1024, 16'hFFFF);
        test_random(300, 71, 16'hFFFF, 16'd1024);
        test_random(300, 71, 16'd12288, 16'd8192);
        test_random(300, 0, IDX_W'($urandom_range(32'hFFFF, 1024)),
                    IDX_W'($urandom_range(32'hFFFF, 1024)));
        test_random(350, 0, IDX_W'($urandom_range(32'hFFFF)), IDX_W'($urandom_range(32'hFFFF)));
        if (mismatches == 0 && expected_q.size() == 0)
            $display("fresnel_dielectric_reflectance_tb OK");
        else
            $display("fresnel_dielectric_reflectance_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("fresnel_dielectric_reflectance_tb NOT OK");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/fresnel_pkg.sv
rtl/core/fresnel_sqrt_stage.sv
rtl/core/fresnel_ratio_stage.sv
rtl/core/fresnel_dielectric_reflectance.sv
test/fresnel_dielectric_reflectance_tb.sv
